### hdl/otf_pkg.sv
// Shared types, widths and rounding helpers for the tangent frame orthonormalizer.
// No dependencies; every other file refers to this package by scoped names.
package otf_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int OUT_W     = 16;
  localparam int FRAC_BITS = 30;
  localparam int OUT_SHIFT = 16;
  localparam int OUT_ONE   = 16384;
  localparam int WIDE_W    = 34;   // signed working vectors before normalization
  localparam int Q_W       = 32;   // signed Q30 unit components
  localparam int NORM_W    = 30;   // magnitudes after alignment
  localparam int ROOT_W    = 31;   // square root of a sum of three squares
  localparam int QUO_W     = 31;   // quotient bits of the final division
  localparam int PROD_W    = 66;   // products and sums of products
  localparam int D_W       = 34;   // rounded dot and cross terms

  typedef logic [2:0][WIDE_W-1:0] wvec_t;

  typedef struct packed {
    wvec_t n;
    wvec_t u;
    wvec_t v;
  } witem_t;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] normal_x;
    logic signed [COMPONENT_WIDTH-1:0] normal_y;
    logic signed [COMPONENT_WIDTH-1:0] normal_z;
    logic signed [COMPONENT_WIDTH-1:0] tan_u_x;
    logic signed [COMPONENT_WIDTH-1:0] tan_u_y;
    logic signed [COMPONENT_WIDTH-1:0] tan_u_z;
    logic signed [COMPONENT_WIDTH-1:0] tan_v_x;
    logic signed [COMPONENT_WIDTH-1:0] tan_v_y;
    logic signed [COMPONENT_WIDTH-1:0] tan_v_z;
  } frame_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_normal_x;
    logic signed [OUT_W-1:0] unit_normal_y;
    logic signed [OUT_W-1:0] unit_normal_z;
    logic signed [OUT_W-1:0] unit_tan_u_x;
    logic signed [OUT_W-1:0] unit_tan_u_y;
    logic signed [OUT_W-1:0] unit_tan_u_z;
    logic signed [OUT_W-1:0] unit_tan_v_x;
    logic signed [OUT_W-1:0] unit_tan_v_y;
    logic signed [OUT_W-1:0] unit_tan_v_z;
  } basis_t;

  // Shift right by the Q30 fraction, rounding half away from zero.
  function automatic logic [PROD_W-1:0] rnd30(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] mag;
    mag = v[PROD_W-1] ? -v : v;
    mag = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[PROD_W-1] ? -mag : mag;
  endfunction

  // Q30 to Q1.14 with rounding and saturation.
  function automatic logic [OUT_W-1:0] to_out(input logic [Q_W-1:0] v);
    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] r;
    mag = v[Q_W-1] ? -v : v;
    r = (mag + (Q_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (r > Q_W'(OUT_ONE)) r = Q_W'(OUT_ONE);
    return v[Q_W-1] ? OUT_W'(-r) : OUT_W'(r);
  endfunction

endpackage

### hdl/orthonormalize_tangent_frame_core.sv
// Tangent frame orthonormalizer: normal and two tangents in, unit Q1.14 basis out.
// Depends on otf_pkg, otf_front, otf_queue and otf_back.
//
// Usage:
//   frame channel: one transaction per frame_valid && !frame_stall, carrying a
//   normal and two tangents as signed 16-bit components of any scale.
//   basis channel: one transaction per accepted frame, in order, carrying the
//   unit normal, unit first tangent and right-handed unit second tangent.
// Throughput: one frame per cycle unless basis_stall holds. Every stage is pipelined; the
//   three square-root and division chains retire one bit per stage.
// Path: from the accepting edge to basis_valid through the queue write, three
//   68-stage normalizers, two 4-stage projection units, three cross/handedness
//   stages and the output register.
// Stall: while basis_stall holds a finished basis, the whole back pipeline
//   freezes; the front keeps accepting until the four-entry queue and its input
//   register fill, then raises frame_stall.
// Reset: rst is synchronous; it drops all in-flight frames and empties the
//   queue. No configuration and no per-item state carry across frames.
module orthonormalize_tangent_frame_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_stall,
  input  otf_pkg::frame_t frame,
  output logic            basis_valid,
  input  logic            basis_stall,
  output otf_pkg::basis_t basis
);
  logic            q_full;
  logic            push;
  otf_pkg::witem_t wr_item;
  logic            take;
  logic            rd_valid;
  otf_pkg::witem_t rd_item;

  otf_front u_front (
    .clk, .rst, .frame_valid, .frame_stall, .frame,
    .q_full, .push, .item(wr_item)
  );

  otf_queue u_queue (
    .clk, .rst, .push, .wr_item, .full(q_full),
    .take, .rd_valid, .rd_item
  );

  otf_back u_back (
    .clk, .rst, .item_valid(rd_valid), .item(rd_item), .take,
    .basis_valid, .basis_stall, .basis
  );
endmodule

### hdl/otf_front.sv
// Front end: registers an incoming frame and widens its components.
// Depends on otf_pkg; feeds otf_queue.
module otf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_stall,
  input  otf_pkg::frame_t frame,
  input  logic            q_full,
  output logic            push,
  output otf_pkg::witem_t item
);
  logic held;

  assign frame_stall = held && q_full;
  assign push        = held && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!frame_stall) begin
      held <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall) begin
      item.n[0] <= otf_pkg::WIDE_W'(frame.normal_x);
      item.n[1] <= otf_pkg::WIDE_W'(frame.normal_y);
      item.n[2] <= otf_pkg::WIDE_W'(frame.normal_z);
      item.u[0] <= otf_pkg::WIDE_W'(frame.tan_u_x);
      item.u[1] <= otf_pkg::WIDE_W'(frame.tan_u_y);
      item.u[2] <= otf_pkg::WIDE_W'(frame.tan_u_z);
      item.v[0] <= otf_pkg::WIDE_W'(frame.tan_v_x);
      item.v[1] <= otf_pkg::WIDE_W'(frame.tan_v_y);
      item.v[2] <= otf_pkg::WIDE_W'(frame.tan_v_z);
    end
  end
endmodule

### hdl/otf_queue.sv
// Four-entry queue between the front end and the arithmetic pipeline.
// Depends on otf_pkg for the item type.
module otf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  otf_pkg::witem_t wr_item,
  output logic            full,
  input  logic            take,
  output logic            rd_valid,
  output otf_pkg::witem_t rd_item
);
  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  otf_pkg::witem_t  mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             pop;

  assign full     = (cnt == CW'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign pop      = take && rd_valid;
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + AW'(1);
      if (pop)  rp <= rp + AW'(1);
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_item;
  end
endmodule

### hdl/otf_norm.sv
// Pipelined normalizer for NV vectors: align, square, bit-serial root stages,
// then one restoring division stage per quotient bit. Depends on otf_pkg.
module otf_norm #(
  parameter int NV     = 1,
  parameter int SIDE_W = 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [NV-1:0][2:0][otf_pkg::WIDE_W-1:0]  in_vec,
  input  logic [SIDE_W-1:0]                        in_side,
  output logic                                     out_valid,
  output logic [NV-1:0][2:0][otf_pkg::Q_W-1:0]     out_vec,
  output logic [SIDE_W-1:0]                        out_side
);
  localparam int WW    = otf_pkg::WIDE_W;
  localparam int NW    = otf_pkg::NORM_W;
  localparam int RW    = otf_pkg::ROOT_W;
  localparam int SW    = 2 * RW;
  localparam int QW    = otf_pkg::QUO_W;
  localparam int MW    = RW + 2;
  localparam int NUM_W = NW + otf_pkg::FRAC_BITS + 1;
  localparam int SH_W  = $clog2(WW);
  localparam int TOP   = NW - 1;
  localparam int NSTG  = 4 + RW + 1 + QW + 1;

  function automatic logic [MW+RW-1:0] root_step(input logic [MW-1:0] rem,
                                                 input logic [RW-1:0] root,
                                                 input logic [1:0]    pair);
    logic [MW+1:0] trial;
    logic [MW+1:0] sub;
    trial = {rem, pair};
    sub   = (MW+2)'({root, 2'b01});
    if (trial >= sub) return {MW'(trial - sub), root[RW-2:0], 1'b1};
    return {trial[MW-1:0], root[RW-2:0], 1'b0};
  endfunction

  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic b,
                                           input logic [RW-1:0] len);
    logic [RW:0] trial;
    trial = {rem, b};
    if (trial >= {1'b0, len}) return {RW'(trial - {1'b0, len}), 1'b1};
    return {trial[RW-1:0], 1'b0};
  endfunction

  logic [NSTG-1:0]             vd;
  logic [NSTG-1:0][SIDE_W-1:0] sd;

  // alignment front stages
  logic [WW-1:0]   mag_c [NV][3];
  logic [2:0]      neg_c [NV];
  logic [WW-1:0]   m_c   [NV];
  logic [WW-1:0]   mag_a [NV][3];
  logic [2:0]      neg_a [NV];
  logic [WW-1:0]   m_a   [NV];
  logic [SH_W-1:0] pos_c [NV];
  logic            right_c [NV];
  logic [SH_W-1:0] amt_c [NV];
  logic [WW-1:0]   mag_b [NV][3];
  logic [3:0]      fl_b  [NV];
  logic            right_b [NV];
  logic [SH_W-1:0] amt_b [NV];
  logic [NW-1:0]   sm_c  [NV][3];
  logic [3:0]      fl_c  [NV];
  logic [NW-1:0]   sm_d  [NV][3];
  logic [2*NW-1:0] sq_d  [NV][3];
  logic [3:0]      fl_d  [NV];

  // root stages
  logic [SW-1:0]   sq_s    [RW+1][NV];
  logic [MW-1:0]   sq_rem  [RW+1][NV];
  logic [RW-1:0]   sq_root [RW+1][NV];
  logic [NW-1:0]   sq_sm   [RW+1][NV][3];
  logic [3:0]      sq_fl   [RW+1][NV];

  // division stages
  logic [RW-1:0]   dv_rem [QW+1][NV][3];
  logic [QW-1:0]   dv_nlo [QW+1][NV][3];
  logic [QW-1:0]   dv_q   [QW+1][NV][3];
  logic [RW-1:0]   dv_len [QW+1][NV];
  logic [3:0]      dv_fl  [QW+1][NV];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) sd <= {sd[NSTG-2:0], in_side};
  end

  assign out_valid = vd[NSTG-1];
  assign out_side  = sd[NSTG-1];

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      for (int i = 0; i < 3; i++) begin
        neg_c[j][i] = in_vec[j][i][WW-1];
        mag_c[j][i] = neg_c[j][i] ? -in_vec[j][i] : in_vec[j][i];
      end
      m_c[j] = mag_c[j][0];
      if (mag_c[j][1] > m_c[j]) m_c[j] = mag_c[j][1];
      if (mag_c[j][2] > m_c[j]) m_c[j] = mag_c[j][2];
    end
  end

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      pos_c[j] = '0;
      for (int k = 0; k < WW; k++) begin
        if (m_a[j][k]) pos_c[j] = SH_W'(k);
      end
      right_c[j] = (pos_c[j] >= SH_W'(TOP));
      amt_c[j]   = right_c[j] ? pos_c[j] - SH_W'(TOP) : SH_W'(TOP) - pos_c[j];
    end
  end

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      fl_c[j] = fl_b[j];
      for (int i = 0; i < 3; i++) begin
        sm_c[j][i] = right_b[j] ? NW'(mag_b[j][i] >> amt_b[j])
                                : NW'(mag_b[j][i] << amt_b[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= mag_c;
      neg_a <= neg_c;
      m_a   <= m_c;
      mag_b <= mag_a;
      right_b <= right_c;
      amt_b <= amt_c;
      for (int j = 0; j < NV; j++) begin
        fl_b[j] <= {(m_a[j] == '0), neg_a[j]};
      end
      sm_d <= sm_c;
      fl_d <= fl_c;
      for (int j = 0; j < NV; j++) begin
        for (int i = 0; i < 3; i++) begin
          sq_d[j][i] <= sm_c[j][i] * sm_c[j][i];
        end
      end
    end
  end

  // sum the squares, then one root bit per stage, most significant pair first
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NV; j++) begin
        sq_s[0][j]    <= SW'(sq_d[j][0]) + SW'(sq_d[j][1]) + SW'(sq_d[j][2]);
        sq_rem[0][j]  <= '0;
        sq_root[0][j] <= '0;
        sq_sm[0][j]   <= sm_d[j];
        sq_fl[0][j]   <= fl_d[j];
      end
      for (int k = 0; k < RW; k++) begin
        for (int j = 0; j < NV; j++) begin
          {sq_rem[k+1][j], sq_root[k+1][j]} <=
            root_step(sq_rem[k][j], sq_root[k][j], sq_s[k][j][2*(RW-1-k)+1 -: 2]);
          sq_s[k+1][j]  <= sq_s[k][j];
          sq_sm[k+1][j] <= sq_sm[k][j];
          sq_fl[k+1][j] <= sq_fl[k][j];
        end
      end
    end
  end

  // form the rounded dividend, then one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    if (en) begin
      for (int j = 0; j < NV; j++) begin
        dv_len[0][j] <= sq_root[RW][j];
        dv_fl[0][j]  <= sq_fl[RW][j];
        for (int i = 0; i < 3; i++) begin
          num = {1'b0, sq_sm[RW][j][i], otf_pkg::FRAC_BITS'(0)}
              + NUM_W'(sq_root[RW][j] >> 1);
          dv_rem[0][j][i] <= RW'(num[NUM_W-1:QW]);
          dv_nlo[0][j][i] <= num[QW-1:0];
          dv_q[0][j][i]   <= '0;
        end
      end
      for (int k = 0; k < QW; k++) begin
        for (int j = 0; j < NV; j++) begin
          dv_len[k+1][j] <= dv_len[k][j];
          dv_fl[k+1][j]  <= dv_fl[k][j];
          for (int i = 0; i < 3; i++) begin
            {dv_rem[k+1][j][i], dv_q[k+1][j][i][0]} <=
              div_step(dv_rem[k][j][i], dv_nlo[k][j][i][QW-1-k], dv_len[k][j]);
            dv_q[k+1][j][i][QW-1:1] <= dv_q[k][j][i][QW-2:0];
            dv_nlo[k+1][j][i]       <= dv_nlo[k][j][i];
          end
        end
      end
    end
  end

  // zero-length vectors stay zero; otherwise restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NV; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_fl[QW][j][3]) begin
            out_vec[j][i] <= '0;
          end else if (dv_fl[QW][j][i]) begin
            out_vec[j][i] <= -{1'b0, dv_q[QW][j][i]};
          end else begin
            out_vec[j][i] <= {1'b0, dv_q[QW][j][i]};
          end
        end
      end
    end
  end
endmodule

### hdl/otf_proj.sv
// Four-stage projection removal: t - rnd(n * rnd(t . n)) for NV vectors t.
// Depends on otf_pkg for widths and rounding.
module otf_proj #(
  parameter int NV     = 1,
  parameter int SIDE_W = 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [NV-1:0][2:0][otf_pkg::Q_W-1:0]    t,
  input  logic [2:0][otf_pkg::Q_W-1:0]            n,
  input  logic [SIDE_W-1:0]                       in_side,
  output logic                                    out_valid,
  output logic [NV-1:0][2:0][otf_pkg::WIDE_W-1:0] out_vec,
  output logic [SIDE_W-1:0]                       out_side
);
  localparam int PW = otf_pkg::PROD_W;

  logic [3:0]               vd;
  logic [3:0][SIDE_W-1:0]   sd;
  logic signed [PW-1:0]     p1 [NV][3];
  logic [2:0][otf_pkg::Q_W-1:0] n1;
  logic [2:0][otf_pkg::Q_W-1:0] n2;
  logic [NV-1:0][2:0][otf_pkg::Q_W-1:0] t1;
  logic [NV-1:0][2:0][otf_pkg::Q_W-1:0] t2;
  logic [NV-1:0][2:0][otf_pkg::Q_W-1:0] t3;
  logic signed [otf_pkg::D_W-1:0] d [NV];
  logic signed [PW-1:0]     pr [NV][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[2:0], in_valid};
    end
  end

  assign out_valid = vd[3];
  assign out_side  = sd[3];

  always_ff @(posedge clk) begin
    logic signed [PW-1:0] sum;
    if (en) begin
      sd <= {sd[2:0], in_side};
      n1 <= n;
      t1 <= t;
      n2 <= n1;
      t2 <= t1;
      t3 <= t2;
      for (int j = 0; j < NV; j++) begin
        for (int i = 0; i < 3; i++) begin
          p1[j][i] <= $signed(t[j][i]) * $signed(n[i]);
        end
        sum  = p1[j][0] + p1[j][1] + p1[j][2];
        d[j] <= otf_pkg::D_W'(otf_pkg::rnd30(sum));
        for (int i = 0; i < 3; i++) begin
          pr[j][i] <= $signed(n2[i]) * d[j];
          out_vec[j][i] <= otf_pkg::WIDE_W'($signed(t3[j][i])
                                            - $signed(otf_pkg::rnd30(pr[j][i])));
        end
      end
    end
  end
endmodule

### hdl/otf_back.sv
// Back end: the Gram-Schmidt chain, handedness check and output register.
// Depends on otf_pkg, otf_norm and otf_proj.
module otf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  otf_pkg::witem_t item,
  output logic            take,
  output logic            basis_valid,
  input  logic            basis_stall,
  output otf_pkg::basis_t basis
);
  localparam int QV = 3 * otf_pkg::Q_W;
  localparam int PW = otf_pkg::PROD_W;

  logic en;
  logic [2:0][2:0][otf_pkg::WIDE_W-1:0] l1_in;
  logic [2:0][2:0][otf_pkg::Q_W-1:0]    l1_out;
  logic l1_valid;
  logic [1:0][2:0][otf_pkg::WIDE_W-1:0] l2_out;
  logic [QV-1:0] l2_side;
  logic l2_valid;
  logic [1:0][2:0][otf_pkg::Q_W-1:0] l3_out;
  logic [QV-1:0] l3_side;
  logic l3_valid;
  logic [0:0][2:0][otf_pkg::WIDE_W-1:0] l4_out;
  logic [2*QV-1:0] l4_side;
  logic l4_valid;
  logic [0:0][2:0][otf_pkg::Q_W-1:0] l5_out;
  logic [2*QV-1:0] l5_side;
  logic l5_valid;

  logic [2:0] xv;
  logic [2:0][otf_pkg::Q_W-1:0] xn1, xu1, xv1, xn2, xu2, xv2, xn3, xu3, xv3;
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [otf_pkg::D_W-1:0] c [3];
  logic signed [PW-1:0] tp [3];

  // hold the whole pipeline while a finished frame waits
  assign en   = !basis_valid || !basis_stall;
  assign take = en;

  assign l1_in[0] = item.n;
  assign l1_in[1] = item.u;
  assign l1_in[2] = item.v;

  otf_norm #(.NV(3), .SIDE_W(1)) u_norm_in (
    .clk, .rst, .en, .in_valid(item_valid), .in_vec(l1_in), .in_side(1'b0),
    .out_valid(l1_valid), .out_vec(l1_out), .out_side()
  );

  otf_proj #(.NV(2), .SIDE_W(QV)) u_proj_n (
    .clk, .rst, .en, .in_valid(l1_valid), .t(l1_out[2:1]), .n(l1_out[0]),
    .in_side(l1_out[0]), .out_valid(l2_valid), .out_vec(l2_out), .out_side(l2_side)
  );

  otf_norm #(.NV(2), .SIDE_W(QV)) u_norm_tan (
    .clk, .rst, .en, .in_valid(l2_valid), .in_vec(l2_out), .in_side(l2_side),
    .out_valid(l3_valid), .out_vec(l3_out), .out_side(l3_side)
  );

  otf_proj #(.NV(1), .SIDE_W(2*QV)) u_proj_u (
    .clk, .rst, .en, .in_valid(l3_valid), .t(l3_out[1:1]), .n(l3_out[0]),
    .in_side({l3_side, l3_out[0]}), .out_valid(l4_valid), .out_vec(l4_out),
    .out_side(l4_side)
  );

  otf_norm #(.NV(1), .SIDE_W(2*QV)) u_norm_v (
    .clk, .rst, .en, .in_valid(l4_valid), .in_vec(l4_out), .in_side(l4_side),
    .out_valid(l5_valid), .out_vec(l5_out), .out_side(l5_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      xv          <= '0;
      basis_valid <= 1'b0;
    end else if (en) begin
      xv          <= {xv[1:0], l5_valid};
      basis_valid <= xv[2];
    end
  end

  // cross product U x V, then its dot with N for the handedness sign
  always_ff @(posedge clk) begin
    logic signed [PW-1:0] triple;
    logic [2:0][otf_pkg::Q_W-1:0] vf;
    if (en) begin
      xn1 <= l5_side[2*QV-1:QV];
      xu1 <= l5_side[QV-1:0];
      xv1 <= l5_out[0];
      for (int i = 0; i < 3; i++) begin
        pa[i] <= $signed(l5_side[(((i+1)%3)*otf_pkg::Q_W) +: otf_pkg::Q_W])
               * $signed(l5_out[0][(i+2)%3]);
        pb[i] <= $signed(l5_side[(((i+2)%3)*otf_pkg::Q_W) +: otf_pkg::Q_W])
               * $signed(l5_out[0][(i+1)%3]);
      end
      xn2 <= xn1;
      xu2 <= xu1;
      xv2 <= xv1;
      for (int i = 0; i < 3; i++) begin
        c[i] <= otf_pkg::D_W'(otf_pkg::rnd30(pa[i] - pb[i]));
      end
      xn3 <= xn2;
      xu3 <= xu2;
      xv3 <= xv2;
      for (int i = 0; i < 3; i++) begin
        tp[i] <= c[i] * $signed(xn2[i]);
      end
      basis.unit_normal_x <= otf_pkg::to_out(xn3[0]);
      basis.unit_normal_y <= otf_pkg::to_out(xn3[1]);
      basis.unit_normal_z <= otf_pkg::to_out(xn3[2]);
      triple = tp[0] + tp[1] + tp[2];
      for (int i = 0; i < 3; i++) begin
        vf[i] = triple[PW-1] ? -xv3[i] : xv3[i];
      end
      basis.unit_tan_u_x <= otf_pkg::to_out(xu3[0]);
      basis.unit_tan_u_y <= otf_pkg::to_out(xu3[1]);
      basis.unit_tan_u_z <= otf_pkg::to_out(xu3[2]);
      basis.unit_tan_v_x <= otf_pkg::to_out(vf[0]);
      basis.unit_tan_v_y <= otf_pkg::to_out(vf[1]);
      basis.unit_tan_v_z <= otf_pkg::to_out(vf[2]);
    end
  end
endmodule
